[design/modbus_rtu_request_framer_macros.svh]
// assertion macros for the modbus rtu request framer checker
// no dependencies; included by files that assert
`ifndef MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH

// overlapping implication, disabled during reset
`define MRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modbus framer assertion failed");

// next-cycle implication, disabled during reset
`define MRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modbus framer assertion failed");

// next-cycle implication that also holds through reset
`define MRF_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("modbus framer reset assertion failed");

`endif

[design/mrf_pkg.sv]
// shared types, codes and crc helper for the modbus rtu request framer
// no dependencies
`timescale 1ns / 1ps

package mrf_pkg;

  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_WRITE_ONE = 2'd1;
  localparam logic [1:0] KIND_WM_HEADER = 2'd2;
  localparam logic [1:0] KIND_WM_DATA   = 2'd3;

  localparam logic [7:0] FN_READ       = 8'h03;
  localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FN_WRITE_MANY = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int JOB_BYTES = 7;
  localparam int STEP_W    = 4;
  localparam logic [1:0] QUEUE_SLOTS = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slave_address;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // one unit of byte work handed from the front to the back
  typedef struct packed {
    logic                         restart;
    logic                         crc_tail;
    logic [2:0]                   nbytes;
    logic [JOB_BYTES-1:0][7:0]    bytes;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  // reflected crc-16 over one byte, bit-serial form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/mrf_front.sv]
// front end: classifies items, tracks the open write-multiple frame, builds jobs
// depends on mrf_pkg
`timescale 1ns / 1ps

module mrf_front import mrf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output job_req_t req
);

  logic [15:0] words_left_r, words_left_nxt;
  logic        open_r, open_nxt;
  logic [7:0]  fn_code;
  logic [15:0] second_word;
  logic [7:0]  twice_count;

  always_comb begin
    case (item.kind)
      KIND_READ:      fn_code = FN_READ;
      KIND_WRITE_ONE: fn_code = FN_WRITE_ONE;
      default:        fn_code = FN_WRITE_MANY;
    endcase
    second_word = (item.kind == KIND_WRITE_ONE) ? item.data_word : item.register_count;
    // byte count keeps only the low 8 bits of twice the count
    twice_count = {item.register_count[6:0], 1'b0};
  end

  always_comb begin
    req            = '0;
    words_left_nxt = words_left_r;
    open_nxt       = open_r;
    if (item.kind == KIND_WM_DATA) begin
      req.valid        = accept && open_r;
      req.job.restart  = 1'b0;
      req.job.nbytes   = 3'd2;
      req.job.crc_tail = (words_left_r == 16'd1);
      req.job.bytes[0] = item.data_word[15:8];
      req.job.bytes[1] = item.data_word[7:0];
      if (accept && open_r) begin
        words_left_nxt = words_left_r - 16'd1;
        open_nxt       = (words_left_r != 16'd1);
      end
    end else begin
      req.valid        = accept;
      req.job.restart  = 1'b1;
      req.job.nbytes   = (item.kind == KIND_WM_HEADER) ? 3'd7 : 3'd6;
      req.job.crc_tail = (item.kind != KIND_WM_HEADER) || (item.register_count == 16'd0);
      req.job.bytes[0] = item.slave_address;
      req.job.bytes[1] = fn_code;
      req.job.bytes[2] = item.start_address[15:8];
      req.job.bytes[3] = item.start_address[7:0];
      req.job.bytes[4] = second_word[15:8];
      req.job.bytes[5] = second_word[7:0];
      req.job.bytes[6] = twice_count;
      if (accept) begin
        // a new request aborts any open frame
        if (item.kind == KIND_WM_HEADER) begin
          words_left_nxt = item.register_count;
          open_nxt       = (item.register_count != 16'd0);
        end else begin
          words_left_nxt = 16'd0;
          open_nxt       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= 16'd0;
      open_r       <= 1'b0;
    end else begin
      words_left_r <= words_left_nxt;
      open_r       <= open_nxt;
    end
  end

endmodule

[design/mrf_job_queue.sv]
// two-slot shifting queue of jobs between front and back
// depends on mrf_pkg
`timescale 1ns / 1ps

module mrf_job_queue import mrf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t wr,
  input  logic     rd_pop,
  output job_req_t rd,
  output logic     q_full
);

  job_t       slot0_r, slot0_nxt;
  job_t       slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (wr.valid) begin
          slot0_nxt = wr.job;
          cnt_nxt   = 2'd1;
        end
      end
      2'd1: begin
        if (wr.valid && rd_pop) begin
          slot0_nxt = wr.job;
        end else if (wr.valid) begin
          slot1_nxt = wr.job;
          cnt_nxt   = 2'd2;
        end else if (rd_pop) begin
          cnt_nxt   = 2'd0;
        end
      end
      default: begin
        if (rd_pop) begin
          slot0_nxt = slot1_r;
          if (wr.valid) begin
            slot1_nxt = wr.job;
          end else begin
            cnt_nxt = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rd.valid = (cnt_r != 2'd0);
  assign rd.job   = slot0_r;
  assign q_full   = (cnt_r == QUEUE_SLOTS);

endmodule

[design/mrf_back.sv]
// back end: walks a job one byte a cycle while the output is free or popped,
// folds bytes into the crc, output register; depends on mrf_pkg
`timescale 1ns / 1ps

module mrf_back import mrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_req_t  job_in,
  output logic      job_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              fire;
  logic [STEP_W-1:0] nb;
  logic [15:0]       crc_base;
  logic              is_last;

  assign nb   = {1'b0, job_in.job.nbytes};
  assign fire = job_in.valid && (!out_valid_r || pop);

  always_comb begin
    step_nxt      = step_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !pop;
    out_item_nxt  = out_item_r;
    job_pop       = 1'b0;
    crc_base      = (step_r == '0 && job_in.job.restart) ? CRC_INIT : crc_r;
    is_last       = job_in.job.crc_tail ? (step_r == nb + 4'd1) : (step_r == nb - 4'd1);
    if (fire) begin
      out_valid_nxt       = 1'b1;
      out_item_nxt.run_last  = is_last;
      out_item_nxt.frame_end = 1'b0;
      if (step_r < nb) begin
        out_item_nxt.frame_byte = job_in.job.bytes[step_r[2:0]];
        crc_nxt = crc_byte(crc_base, job_in.job.bytes[step_r[2:0]]);
      end else if (step_r == nb) begin
        // crc low byte first
        out_item_nxt.frame_byte = crc_r[7:0];
      end else begin
        out_item_nxt.frame_byte = crc_r[15:8];
        out_item_nxt.frame_end  = 1'b1;
        crc_nxt = CRC_INIT;
      end
      if (is_last) begin
        step_nxt = '0;
        job_pop  = 1'b1;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

endmodule

[design/modbus_rtu_request_framer.sv]
// top level of the modbus rtu request framer
// depends on mrf_pkg, mrf_front, mrf_job_queue, mrf_back
`timescale 1ns / 1ps

// Turns request items into a Modbus RTU master byte stream with CRC-16
// (reflected 0xA001, seed 0xFFFF, low byte first), one output transfer per
// byte. A read or write-single item yields 8 bytes, a write-multiple header
// 7 bytes (9 when its count is zero), each data word 2 bytes and the last
// word 4 bytes with the CRC; a stray data word yields nothing. An item is
// taken in any cycle in which the two-slot job queue has room, so items
// arrive back to back while earlier frames still drain. Sustained rate is set
// by the byte sequencer in the back end, which sends one byte per cycle while
// pop is held high.
// The CRC is updated over a whole byte in the same cycle the byte is sent.
module modbus_rtu_request_framer import mrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // input queue side
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  // result queue side
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  job_req_t front_req;   // job built from the accepted item
  job_req_t head_req;    // oldest job waiting for the back end
  logic     head_pop;    // back end finished the head job
  logic     q_full;
  logic     in_accept;

  // input transfer happens whenever the queue can take a job
  assign in_accept = push && !q_full;
  assign full      = q_full;

  // classifies items and keeps the write-multiple frame bookkeeping
  mrf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_item),
    .req    (front_req)
  );

  // decouples item intake from byte output
  mrf_job_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (front_req),
    .rd_pop (head_pop),
    .rd     (head_req),
    .q_full (q_full)
  );

  // byte sequencer, crc and output register
  mrf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_in   (head_req),
    .job_pop  (head_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

[design/mrf_checker.sv]
// port-level checks for the modbus rtu request framer, bound to the top level
// depends on mrf_pkg and modbus_rtu_request_framer_macros.svh
`timescale 1ns / 1ps
`include "modbus_rtu_request_framer_macros.svh"

module mrf_checker import mrf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // a waiting result holds until it is taken
  `MRF_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))

  // the closing crc byte always ends the run of its item
  `MRF_ASSERT_IMP(a_end_last, clk, rst_n, !empty && out_item.frame_end, out_item.run_last)

  // reset leaves no result pending and room for input
  `MRF_ASSERT_RST(a_reset, clk, !rst_n, empty && !full)

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
